// ----- rtl/core/dtuc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dtuc_pkg;

   localparam int TIME_WIDTH = 16;
   localparam int CNT_WIDTH  = 16;
   localparam int COMP_WIDTH = 5;
   localparam int CUP_WIDTH  = 4;

   typedef enum logic [1:0] {
      REQ_TICK   = 2'd0,
      REQ_START  = 2'd1,
      REQ_CANCEL = 2'd2,
      REQ_UNUSED = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      LEVEL_MID  = 2'd0,
      LEVEL_LOW  = 2'd1,
      LEVEL_FULL = 2'd2,
      LEVEL_ERR  = 2'd3
   } level_type;

   typedef enum logic [1:0] {
      OUTLET_PURE  = 2'd0,
      OUTLET_HOT   = 2'd1,
      OUTLET_COLD  = 2'd2,
      OUTLET_OTHER = 2'd3
   } outlet_type;

   typedef enum logic [1:0] {
      CSR_NORMAL_MAX  = 2'd0,
      CSR_LOW_MAX     = 2'd1,
      CSR_FEED_PERIOD = 2'd2,
      CSR_NONE        = 2'd3
   } csr_index_type;

   localparam logic [CUP_WIDTH-1:0] CUP_NONE = CUP_WIDTH'(8);

   typedef struct packed {
      logic [1:0]            req_type;
      logic [TIME_WIDTH-1:0] base_time;
      logic [CUP_WIDTH-1:0]  cup_size;
      logic [1:0]            outlet;
      logic                  hot_lowest_setting;
      logic [1:0]            water_level;
      logic                  feed_open;
      logic                  drain_open;
      logic                  startup_done;
   } req_item_type;

   typedef struct packed {
      logic                  dispensing;
      logic                  done_pulse;
      logic                  abort_pulse;
      logic [TIME_WIDTH-1:0] target_ticks;
      logic [TIME_WIDTH-1:0] elapsed_ticks;
      logic [CNT_WIDTH-1:0]  normal_count;
      logic [CNT_WIDTH-1:0]  low_count;
      logic [COMP_WIDTH-1:0] compensation;
   } rsp_item_type;

   typedef struct packed {
      logic                  active;
      logic [TIME_WIDTH-1:0] elapsed;
      logic [TIME_WIDTH-1:0] target;
      logic [CUP_WIDTH-1:0]  held_cup;
      logic [1:0]            held_outlet;
      logic [CNT_WIDTH-1:0]  usage_normal;
      logic [CNT_WIDTH-1:0]  usage_low;
      logic [CNT_WIDTH-1:0]  feed_ticks;
      logic [COMP_WIDTH-1:0] last_comp;
   } state_type;

   typedef struct packed {
      logic [CNT_WIDTH-1:0] normal_count_max;
      logic [CNT_WIDTH-1:0] low_count_max;
      logic [CNT_WIDTH-1:0] feed_period_ticks;
   } cfg_type;

   function automatic logic [2:0] cup_inc(input logic [2:0] cup);
      logic [2:0] r;
      case (cup)
         3'd0, 3'd1: r = 3'd1;
         3'd2, 3'd3: r = 3'd2;
         3'd4, 3'd5: r = 3'd3;
         3'd6:       r = 3'd4;
         default:    r = 3'd5;
      endcase
      return r;
   endfunction

   function automatic logic [CNT_WIDTH-1:0] sat_add(input logic [CNT_WIDTH-1:0] cnt,
                                                    input logic [2:0]           inc,
                                                    input logic [CNT_WIDTH-1:0] max);
      logic [CNT_WIDTH:0] s;
      s = {1'b0, cnt} + {{(CNT_WIDTH-2){1'b0}}, inc};
      return (s >= {1'b0, max}) ? max : s[CNT_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dtuc_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface dtuc_req_if;
   logic                             valid;
   logic                             ready;
   logic [1:0]                       req_type;
   logic [dtuc_pkg::TIME_WIDTH-1:0]  base_time;
   logic [dtuc_pkg::CUP_WIDTH-1:0]   cup_size;
   logic [1:0]                       outlet;
   logic                             hot_lowest_setting;
   logic [1:0]                       water_level;
   logic                             feed_open;
   logic                             drain_open;
   logic                             startup_done;

   modport source (output valid, req_type, base_time, cup_size, outlet, hot_lowest_setting,
                   water_level, feed_open, drain_open, startup_done, input ready);
   modport sink   (input valid, req_type, base_time, cup_size, outlet, hot_lowest_setting,
                   water_level, feed_open, drain_open, startup_done, output ready);
endinterface

interface dtuc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             dispensing;
   logic                             done_pulse;
   logic                             abort_pulse;
   logic [dtuc_pkg::TIME_WIDTH-1:0]  target_ticks;
   logic [dtuc_pkg::TIME_WIDTH-1:0]  elapsed_ticks;
   logic [dtuc_pkg::CNT_WIDTH-1:0]   normal_count;
   logic [dtuc_pkg::CNT_WIDTH-1:0]   low_count;
   logic [dtuc_pkg::COMP_WIDTH-1:0]  compensation;

   modport source (output valid, dispensing, done_pulse, abort_pulse, target_ticks,
                   elapsed_ticks, normal_count, low_count, compensation, input ready);
   modport sink   (input valid, dispensing, done_pulse, abort_pulse, target_ticks,
                   elapsed_ticks, normal_count, low_count, compensation, output ready);
endinterface

interface dtuc_csr_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      index;
   logic [dtuc_pkg::CNT_WIDTH-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/dtuc_comp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dtuc_comp (
   input  wire logic [1:0]                       outlet,
   input  wire logic                             hot_lowest_setting,
   input  wire logic [1:0]                       water_level,
   input  wire logic [dtuc_pkg::CNT_WIDTH-1:0]   usage_normal,
   input  wire logic [dtuc_pkg::CNT_WIDTH-1:0]   usage_low,
   output      logic [dtuc_pkg::COMP_WIDTH-1:0]  comp
);

   always_comb begin
      if (outlet == dtuc_pkg::OUTLET_HOT && hot_lowest_setting) begin
         comp = '0;
      end else if (water_level == dtuc_pkg::LEVEL_LOW) begin
         if      (usage_low <= dtuc_pkg::CNT_WIDTH'(3))  comp = dtuc_pkg::COMP_WIDTH'(0);
         else if (usage_low <= dtuc_pkg::CNT_WIDTH'(6))  comp = dtuc_pkg::COMP_WIDTH'(4);
         else if (usage_low <= dtuc_pkg::CNT_WIDTH'(9))  comp = dtuc_pkg::COMP_WIDTH'(7);
         else if (usage_low <= dtuc_pkg::CNT_WIDTH'(12)) comp = dtuc_pkg::COMP_WIDTH'(12);
         else                                            comp = dtuc_pkg::COMP_WIDTH'(16);
      end else begin
         if      (usage_normal <= dtuc_pkg::CNT_WIDTH'(4))  comp = dtuc_pkg::COMP_WIDTH'(0);
         else if (usage_normal <= dtuc_pkg::CNT_WIDTH'(8))  comp = dtuc_pkg::COMP_WIDTH'(4);
         else if (usage_normal <= dtuc_pkg::CNT_WIDTH'(12)) comp = dtuc_pkg::COMP_WIDTH'(7);
         else if (usage_normal <= dtuc_pkg::CNT_WIDTH'(15)) comp = dtuc_pkg::COMP_WIDTH'(10);
         else                                               comp = dtuc_pkg::COMP_WIDTH'(11);
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/dtuc_step.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dtuc_step (
   input  wire dtuc_pkg::req_item_type  item,
   input  wire dtuc_pkg::state_type     cur,
   input  wire dtuc_pkg::cfg_type       cfg,
   output      dtuc_pkg::state_type     nxt,
   output      dtuc_pkg::rsp_item_type  rsp
);

   logic [dtuc_pkg::COMP_WIDTH-1:0] comp;

   dtuc_comp u_comp (
      .outlet             (item.outlet),
      .hot_lowest_setting (item.hot_lowest_setting),
      .water_level        (item.water_level),
      .usage_normal       (cur.usage_normal),
      .usage_low          (cur.usage_low),
      .comp               (comp)
   );

   always_comb begin
      logic [dtuc_pkg::TIME_WIDTH:0]   sum;
      logic [dtuc_pkg::TIME_WIDTH-1:0] el1;
      logic [dtuc_pkg::CNT_WIDTH-1:0]  ft1;
      logic                            low;
      logic                            done;
      logic                            abrt;

      nxt  = cur;
      done = 1'b0;
      abrt = 1'b0;
      low  = (item.water_level == dtuc_pkg::LEVEL_LOW);
      sum  = {1'b0, item.base_time} +
             {{(dtuc_pkg::TIME_WIDTH+1-dtuc_pkg::COMP_WIDTH){1'b0}}, comp};
      el1  = cur.elapsed + dtuc_pkg::TIME_WIDTH'(1);
      ft1  = cur.feed_ticks + dtuc_pkg::CNT_WIDTH'(1);

      case (item.req_type)
         dtuc_pkg::REQ_START: begin
            nxt.last_comp   = comp;
            nxt.target      = sum[dtuc_pkg::TIME_WIDTH] ? '1 : sum[dtuc_pkg::TIME_WIDTH-1:0];
            nxt.elapsed     = '0;
            nxt.active      = 1'b1;
            nxt.held_cup    = item.cup_size;
            nxt.held_outlet = item.outlet;
         end
         dtuc_pkg::REQ_CANCEL: begin
            nxt.active  = 1'b0;
            nxt.elapsed = '0;
            nxt.target  = '0;
         end
         dtuc_pkg::REQ_TICK: begin
            if (cur.active) begin
               if (el1 >= cur.target) begin
                  nxt.active  = 1'b0;
                  nxt.elapsed = '0;
                  nxt.target  = '0;
                  done        = 1'b1;
                  if (cur.held_cup < dtuc_pkg::CUP_NONE) begin
                     if (low) begin
                        nxt.usage_low = dtuc_pkg::sat_add(cur.usage_low,
                           dtuc_pkg::cup_inc(cur.held_cup[2:0]), cfg.low_count_max);
                     end else begin
                        nxt.usage_normal = dtuc_pkg::sat_add(cur.usage_normal,
                           dtuc_pkg::cup_inc(cur.held_cup[2:0]), cfg.normal_count_max);
                     end
                  end
               end else if ((cur.held_outlet == dtuc_pkg::OUTLET_HOT ||
                             cur.held_outlet == dtuc_pkg::OUTLET_PURE) && low) begin
                  nxt.active  = 1'b0;
                  nxt.elapsed = '0;
                  nxt.target  = '0;
                  abrt        = 1'b1;
               end else begin
                  nxt.elapsed = el1;
               end
            end else begin
               nxt.elapsed = '0;
            end

            // feed accounting
            if (!item.startup_done || item.water_level == dtuc_pkg::LEVEL_FULL ||
                item.water_level == dtuc_pkg::LEVEL_ERR) begin
               nxt.feed_ticks   = '0;
               nxt.usage_normal = '0;
               nxt.usage_low    = '0;
            end else begin
               if (low) begin
                  nxt.usage_normal = cfg.normal_count_max;
               end
               if (item.feed_open && !item.drain_open) begin
                  if (ft1 >= cfg.feed_period_ticks) begin
                     nxt.feed_ticks = '0;
                     if (low) begin
                        if (nxt.usage_low != '0) begin
                           nxt.usage_low = nxt.usage_low - dtuc_pkg::CNT_WIDTH'(1);
                        end
                     end else begin
                        if (nxt.usage_normal != '0) begin
                           nxt.usage_normal = nxt.usage_normal - dtuc_pkg::CNT_WIDTH'(1);
                        end
                     end
                  end else begin
                     nxt.feed_ticks = ft1;
                  end
               end else begin
                  nxt.feed_ticks = '0;
               end
            end
         end
         default: begin
         end
      endcase

      rsp.dispensing    = nxt.active;
      rsp.done_pulse    = done;
      rsp.abort_pulse   = abrt;
      rsp.target_ticks  = nxt.target;
      rsp.elapsed_ticks = nxt.elapsed;
      rsp.normal_count  = nxt.usage_normal;
      rsp.low_count     = nxt.usage_low;
      rsp.compensation  = nxt.last_comp;
   end

endmodule

`default_nettype wire

// ----- rtl/core/dispense_timer_with_usage_compensation.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel    Port       Dir  Carries
// request    req_chan   in   tick / start / cancel item with level and valve inputs
// response   rsp_chan   out  dispense status, timer values, usage counters
// config     csr_chan   in   register index and write data
//
// One item per cycle sustained while rsp_chan is ready; an item's result reaches rsp_chan once
// it advances (input register on acceptance, state update into the result register on advance).
// All state advances when the input register hands its item to the result register.
// Synchronous active-high reset; config is written at once, csr_chan.ready is always high.
// A stalled rsp_chan holds the result register; req_chan keeps accepting until both
// registers are full.

module dispense_timer_with_usage_compensation (
   input wire logic clock,
   input wire logic reset,
   dtuc_req_if.sink   req_chan,
   dtuc_rsp_if.source rsp_chan,
   dtuc_csr_if.sink   csr_chan
);

   logic                    in_valid_ff;
   logic                    in_valid_in;
   dtuc_pkg::req_item_type  in_item_ff;
   logic                    out_valid_ff;
   logic                    out_valid_in;
   dtuc_pkg::rsp_item_type  out_item_ff;
   dtuc_pkg::rsp_item_type  out_item_in;
   dtuc_pkg::state_type     st_ff;
   dtuc_pkg::state_type     st_in;
   dtuc_pkg::cfg_type       cfg_ff;
   dtuc_pkg::cfg_type       cfg_in;
   dtuc_pkg::req_item_type  req_item;
   logic                    advance;
   logic                    req_take;

   assign req_item.req_type           = req_chan.req_type;
   assign req_item.base_time          = req_chan.base_time;
   assign req_item.cup_size           = req_chan.cup_size;
   assign req_item.outlet             = req_chan.outlet;
   assign req_item.hot_lowest_setting = req_chan.hot_lowest_setting;
   assign req_item.water_level        = req_chan.water_level;
   assign req_item.feed_open          = req_chan.feed_open;
   assign req_item.drain_open         = req_chan.drain_open;
   assign req_item.startup_done       = req_chan.startup_done;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   dtuc_step u_step (
      .item (in_item_ff),
      .cur  (st_ff),
      .cfg  (cfg_ff),
      .nxt  (st_in),
      .rsp  (out_item_in)
   );

   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);
      cfg_in       = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            dtuc_pkg::CSR_NORMAL_MAX:  cfg_in.normal_count_max  = csr_chan.data;
            dtuc_pkg::CSR_LOW_MAX:     cfg_in.low_count_max     = csr_chan.data;
            dtuc_pkg::CSR_FEED_PERIOD: cfg_in.feed_period_ticks = csr_chan.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         cfg_ff.normal_count_max  <= dtuc_pkg::CNT_WIDTH'(28);
         cfg_ff.low_count_max     <= dtuc_pkg::CNT_WIDTH'(14);
         cfg_ff.feed_period_ticks <= dtuc_pkg::CNT_WIDTH'(600);
         st_ff.active       <= 1'b0;
         st_ff.elapsed      <= '0;
         st_ff.target       <= '0;
         st_ff.held_cup     <= dtuc_pkg::CUP_NONE;
         st_ff.held_outlet  <= dtuc_pkg::OUTLET_OTHER;
         st_ff.usage_normal <= '0;
         st_ff.usage_low    <= '0;
         st_ff.feed_ticks   <= '0;
         st_ff.last_comp    <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff       <= cfg_in;
         if (advance) begin
            st_ff <= st_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_item_ff <= out_item_in;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.dispensing    = out_item_ff.dispensing;
   assign rsp_chan.done_pulse    = out_item_ff.done_pulse;
   assign rsp_chan.abort_pulse   = out_item_ff.abort_pulse;
   assign rsp_chan.target_ticks  = out_item_ff.target_ticks;
   assign rsp_chan.elapsed_ticks = out_item_ff.elapsed_ticks;
   assign rsp_chan.normal_count  = out_item_ff.normal_count;
   assign rsp_chan.low_count     = out_item_ff.low_count;
   assign rsp_chan.compensation  = out_item_ff.compensation;

`ifndef SYNTHESIS
   a_pulse_excl: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_item_ff.done_pulse && out_item_ff.abort_pulse))
      else $error("done and abort in the same item");

   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_item_ff.done_pulse || out_item_ff.abort_pulse)
      |-> !out_item_ff.dispensing && out_item_ff.target_ticks == '0)
      else $error("dispense still active after end");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(st_ff))
      else $error("state changed without an item");

   a_item_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("pending item dropped");
`endif

endmodule

`default_nettype wire
